@@ design/npcl_pkg.sv @@
// Package for the nearest palette color matcher: payload structs, sequencer
// states, register map and the fixed-point constant tables.
// Depends on nothing; imported by nearest_palette_color_lab and the testbench.
`default_nettype none

package npcl_pkg;

	localparam int DEFAULT_PALETTE_DEPTH = 16;

	// register map (index = paddr[2])
	localparam logic REG_PALETTE_COUNT = 1'b0;

	typedef struct packed {
		logic       func;
		logic [3:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_t;

	typedef struct packed {
		logic [3:0] match_index;
		logic       found;
	} out_t;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_XYZ,
		ST_CURVE,
		ST_DN,
		ST_DM,
		ST_DQ,
		ST_DC,
		ST_CM,
		ST_CS,
		ST_LAB0,
		ST_LAB1,
		ST_LAB2,
		ST_LAB3,
		ST_WR,
		ST_SRD,
		ST_SQ,
		ST_DONE
	} state_t;

	// linear segment of the Lab curve: (390224*t + CURVE_OFS) / 3132
	localparam logic [18:0] CURVE_SLOPE = 19'd390224;
	localparam logic [29:0] CURVE_OFS   = 30'd452986398;
	localparam logic [11:0] CURVE_DIV   = 12'd3132;
	// floor(2^42 / 3132); quotient comes out exact or one low
	localparam logic [30:0] CURVE_RECIP = 31'd1404229409;
	localparam logic [16:0] CURVE_KNEE  = 17'd580;
	localparam logic [16:0] T_MAX       = 17'd65536;

	typedef logic [255:0][16:0] lin_table_t;

	function automatic longint unsigned pow5_q24(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int i = 0; i < 4; i++) begin
			p = (p * r) >> 24;
		end
		return p;
	endfunction

	// sRGB to linear, Q16, evaluated at elaboration
	function automatic lin_table_t build_lin_table();
		lin_table_t tbl;
		longint unsigned s, q, lo, hi, mid;
		for (int c = 0; c < 256; c++) begin
			if (longint'(c) * 100000 <= 1031475) begin
				tbl[c] = 17'((longint'(c) * 6553600 + 164730) / 329460);
			end else begin
				s = ((longint'(c) * 1000 + 14025) * 16777216 + 134512) / 269025;
				q = (s * s) >> 24;
				lo = 0;
				hi = 16777216;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (pow5_q24(mid) <= q)
						lo = mid;
					else
						hi = mid - 1;
				end
				tbl[c] = 17'((((q * lo) >> 24) + 128) >> 8);
			end
		end
		return tbl;
	endfunction

	localparam lin_table_t LIN_TABLE = build_lin_table();

	// RGB to XYZ over white point, Q16
	function automatic logic [15:0] xyz_coef(input logic [1:0] row, input logic [1:0] col);
		logic [15:0] v;
		case ({row, col})
			4'h0: v = 16'd28439;
			4'h1: v = 16'd24655;
			4'h2: v = 16'd12441;
			4'h4: v = 16'd13938;
			4'h5: v = 16'd46868;
			4'h6: v = 16'd4730;
			4'h8: v = 16'd1164;
			4'h9: v = 16'd7174;
			4'hA: v = 16'd57198;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ design/nearest_palette_color_lab.sv @@
// Nearest palette color in CIE Lab: sRGB-to-Lab conversion and palette scan
// around one shared multiplier. Depends on npcl_pkg.
//
// A load converts each XYZ row through the cube-root path, the linear path or
// the full-scale shortcut, then forms Lab and writes the palette entry. A query
// converts the same way, then scans the palette entries and hands the result to
// the output register. One request at a time.
// Reset clears the sequencer, the output valid and palette_count; palette
// memory is not cleared.
`default_nettype none

module nearest_palette_color_lab
	import npcl_pkg::*;
#(
	parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire in_t         in_data,
	// result channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      out_t        out_data,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	state_t state_q, state_d;

	// ---------------- configuration ----------------
	logic [4:0] count_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PALETTE_COUNT) ? {27'b0, count_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PALETTE_COUNT) begin
			count_q <= pwdata[4:0];
		end
	end

	// count saturated to the depth
	logic [7:0] count_sat;
	assign count_sat = (8'(count_q) > 8'(PALETTE_DEPTH)) ? 8'(PALETTE_DEPTH) : 8'(count_q);

	// ---------------- request capture ----------------
	logic             func_q;
	logic [3:0]       entry_q;
	logic [16:0]      lin_q [3];
	logic [CNT_W-1:0] n_q;
	wire              accept = in_valid && !in_stall;

	// ---------------- shared multiplier ----------------
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// ---------------- datapath registers ----------------
	logic [1:0]  row_q, k_q;
	logic [35:0] acc_q;
	logic [29:0] n_lin_q;     // numerator on the linear curve segment
	logic [19:0] q0_q;
	logic [59:0] x_q;         // cube-root remainder
	logic [20:0] y_q;         // cube-root partial result
	logic [5:0]  s_q;         // cube-root bit position
	logic [20:0] f_q [3];
	logic [15:0] lab_l_q, lab_a_q, lab_b_q;

	// curve input from the XYZ sum, clamped to one
	logic [20:0] t_raw;
	logic [16:0] t_c;
	assign t_raw = 21'((acc_q + 36'd32768) >> 16);
	assign t_c   = (t_raw >= 21'(T_MAX)) ? T_MAX : t_raw[16:0];

	// cube-root step
	logic [41:0] cr_p;
	logic [43:0] cr_b;
	logic [59:0] cr_xs;
	logic        cr_take;
	logic [20:0] y2, y_new;
	assign y2      = {y_q[19:0], 1'b0};
	assign cr_p    = mul_q[41:0];
	assign cr_b    = {1'b0, cr_p, 1'b0} + {2'b0, cr_p} + 44'd1;
	assign cr_xs   = x_q >> s_q;
	assign cr_take = cr_xs >= {16'b0, cr_b};
	assign y_new   = cr_take ? (y2 + 21'd1) : y2;

	// linear segment correction
	logic [29:0] dc_rem;
	assign dc_rem = n_lin_q - mul_q[29:0];

	// Lab rounding, halves up
	logic signed [65:0] lab_rnd;
	assign lab_rnd = (mul_q + 66'sd524288) >>> 20;

	logic signed [21:0] dfa, dfb;
	assign dfa = $signed({1'b0, f_q[0]}) - $signed({1'b0, f_q[1]});
	assign dfb = $signed({1'b0, f_q[1]}) - $signed({1'b0, f_q[2]});

	// ---------------- palette memory ----------------
	logic [47:0]      mem [PALETTE_DEPTH];
	logic [47:0]      rd_q;
	logic [CNT_W-1:0] scan_j_q;
	logic [7:0]       scan_j8, entry8;
	logic             slot_ok;
	assign scan_j8 = 8'(scan_j_q);
	assign entry8  = 8'(entry_q);
	assign slot_ok = entry8 < 8'(PALETTE_DEPTH);

	always_ff @(posedge clk) begin
		if (state_q == ST_WR && slot_ok)
			mem[entry8[IDX_W-1:0]] <= {lab_l_q, lab_a_q, lab_b_q};
		rd_q <= mem[scan_j8[IDX_W-1:0]];
	end

	// scan distances
	logic signed [16:0] dl, da, db, dsel;
	assign dl = $signed({lab_l_q[15], lab_l_q}) - $signed({rd_q[47], rd_q[47:32]});
	assign da = $signed({lab_a_q[15], lab_a_q}) - $signed({rd_q[31], rd_q[31:16]});
	assign db = $signed({lab_b_q[15], lab_b_q}) - $signed({rd_q[15], rd_q[15:0]});

	logic [35:0] sum_d;
	assign sum_d = acc_q + mul_q[35:0];

	logic             best_found_q;
	logic [35:0]      best_q;
	logic [CNT_W-1:0] best_j_q;
	logic             scan_last;
	assign scan_last = (scan_j_q + CNT_W'(1)) == n_q;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_XYZ;
			ST_XYZ:   if (k_q == 2'd3) state_d = ST_CURVE;
			ST_CURVE: begin
				if (t_c == T_MAX)
					state_d = (row_q == 2'd2) ? ST_LAB0 : ST_XYZ;
				else if (t_c > CURVE_KNEE)
					state_d = ST_CM;
				else
					state_d = ST_DN;
			end
			ST_DN:    state_d = ST_DM;
			ST_DM:    state_d = ST_DQ;
			ST_DQ:    state_d = ST_DC;
			ST_DC:    state_d = (row_q == 2'd2) ? ST_LAB0 : ST_XYZ;
			ST_CM:    state_d = ST_CS;
			ST_CS: begin
				if (s_q != 6'd0)
					state_d = ST_CM;
				else
					state_d = (row_q == 2'd2) ? ST_LAB0 : ST_XYZ;
			end
			ST_LAB0:  state_d = ST_LAB1;
			ST_LAB1:  state_d = ST_LAB2;
			ST_LAB2:  state_d = ST_LAB3;
			ST_LAB3: begin
				if (func_q == FUNC_LOAD)
					state_d = ST_WR;
				else if (n_q == '0)
					state_d = ST_DONE;
				else
					state_d = ST_SRD;
			end
			ST_WR:    state_d = ST_IDLE;
			ST_SRD:   state_d = ST_SQ;
			ST_SQ: begin
				if (k_q == 2'd3)
					state_d = scan_last ? ST_DONE : ST_SRD;
			end
			ST_DONE:  if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		dsel     = dl;
		case (state_q)
			ST_XYZ: begin
				if (k_q != 2'd3) begin
					mul_a = $signed({17'b0, xyz_coef(row_q, k_q)});
					mul_b = $signed({16'b0, lin_q[k_q]});
				end
			end
			ST_CURVE: begin
				mul_a = $signed({14'b0, CURVE_SLOPE});
				mul_b = $signed({16'b0, t_c});
			end
			ST_DM: begin
				mul_a = $signed({3'b0, n_lin_q});
				mul_b = $signed({2'b0, CURVE_RECIP});
			end
			ST_DQ: begin
				mul_a = $signed({13'b0, mul_q[61:42]});
				mul_b = $signed({21'b0, CURVE_DIV});
			end
			ST_CM: begin
				mul_a = $signed({12'b0, y2});
				mul_b = $signed({12'b0, y2 + 21'd1});
			end
			ST_LAB0: begin
				mul_a = 33'sd7424;
				mul_b = $signed({12'b0, f_q[1]});
			end
			ST_LAB1: begin
				mul_a = 33'sd32000;
				mul_b = {{11{dfa[21]}}, dfa};
			end
			ST_LAB2: begin
				mul_a = 33'sd12800;
				mul_b = {{11{dfb[21]}}, dfb};
			end
			ST_SQ: begin
				case (k_q)
					2'd0:    dsel = dl;
					2'd1:    dsel = da;
					default: dsel = db;
				endcase
				if (k_q != 2'd3) begin
					mul_a = {{16{dsel[16]}}, dsel};
					mul_b = {{16{dsel[16]}}, dsel};
				end
			end
			default: ;
		endcase
	end

	// ---------------- sequencer and datapath registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q   <= in_data.func;
					entry_q  <= in_data.entry_index;
					lin_q[0] <= LIN_TABLE[in_data.red];
					lin_q[1] <= LIN_TABLE[in_data.green];
					lin_q[2] <= LIN_TABLE[in_data.blue];
					n_q      <= count_sat[CNT_W-1:0];
					row_q    <= 2'd0;
					k_q      <= 2'd0;
				end
			end
			ST_XYZ: begin
				acc_q <= (k_q == 2'd0) ? 36'd0 : sum_d;
				k_q   <= k_q + 2'd1;
			end
			ST_CURVE: begin
				k_q <= 2'd0;
				x_q <= {t_c[15:0], 44'b0};
				y_q <= '0;
				s_q <= 6'd57;
				if (t_c == T_MAX) begin
					f_q[row_q] <= 21'd1048576;
					row_q      <= row_q + 2'd1;
				end
			end
			ST_DN: n_lin_q <= mul_q[29:0] + CURVE_OFS;
			ST_DQ: q0_q    <= mul_q[61:42];
			ST_DC: begin
				f_q[row_q] <= {1'b0, q0_q} + ((dc_rem >= 30'(CURVE_DIV)) ? 21'd1 : 21'd0);
				row_q      <= row_q + 2'd1;
			end
			ST_CS: begin
				if (cr_take)
					x_q <= x_q - 60'({16'b0, cr_b} << s_q);
				y_q <= y_new;
				s_q <= s_q - 6'd3;
				if (s_q == 6'd0) begin
					f_q[row_q] <= y_new;
					row_q      <= row_q + 2'd1;
				end
			end
			ST_LAB1: lab_l_q <= lab_rnd[15:0] - 16'd1024;
			ST_LAB2: lab_a_q <= lab_rnd[15:0];
			ST_LAB3: begin
				lab_b_q  <= lab_rnd[15:0];
				scan_j_q <= '0;
				k_q      <= 2'd0;
			end
			ST_SQ: begin
				acc_q <= (k_q == 2'd0) ? 36'd0 : sum_d;
				k_q   <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					if (!best_found_q || sum_d < best_q) begin
						best_q   <= sum_d;
						best_j_q <= scan_j_q;
					end
					scan_j_q <= scan_j_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// best-so-far flag is control: cleared at reset and at each query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			best_found_q <= 1'b0;
		else if (state_q == ST_LAB3)
			best_found_q <= 1'b0;
		else if (state_q == ST_SQ && k_q == 2'd3)
			best_found_q <= 1'b1;
	end

	// ---------------- output register ----------------
	logic [7:0] best_j8;
	wire        out_load = (state_q == ST_DONE) && (!out_valid || !out_stall);
	assign best_j8 = 8'(best_j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.found       <= best_found_q;
			out_data.match_index <= best_found_q ? best_j8[3:0] : 4'd0;
		end
	end

	// ---------------- assertions ----------------
	// no result rises in the cycle after its request is accepted
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !$rose(out_valid))
		else $error("result appeared one cycle after a request");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.match_index == 4'd0)
		else $error("not-found result with nonzero index");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ |-> scan_j_q < n_q)
		else $error("scan index past palette count");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for nearest_palette_color_lab: palette loads and
// nearest-color queries with an in-bench Lab predictor and result scoreboard.
// Depends on npcl_pkg and the nearest_palette_color_lab RTL.
`default_nettype none

module testbench;
	import npcl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 16;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_WAIT  = 300;

	typedef struct {
		int l;
		int a;
		int b;
	} lab_color_t;

	// Q16 RGB-to-XYZ rows, already divided by the D65 white point
	localparam longint unsigned RGB2XYZ [3][3] = '{
		'{28439, 24655, 12441},
		'{13938, 46868,  4730},
		'{ 1164,  7174, 57198}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	nearest_palette_color_lab i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state: its own copy of the palette and the count register
	lab_color_t      palette_model [DEPTH];
	logic [4:0]      count_model;
	longint unsigned srgb_to_lin [256];

	in_t  pending_requests[$];   // requests not yet offered
	out_t expected_matches[$];   // one entry per accepted query
	logic [7:0] loaded_rgb [DEPTH][3];

	int unsigned mismatches;
	logic        quiet;           // no idling on either side
	logic        long_hold;       // receiver holds off for a long stretch
	logic        hold_request;
	int unsigned tx_gap;
	int unsigned rx_gap;

	// ---------------------------------------------------------------
	// Fixed-point color math
	// ---------------------------------------------------------------
	function automatic longint unsigned fifth_power_q24(longint unsigned r);
		longint unsigned p;
		p = r;
		repeat (4) p = (p * r) >> 24;
		return p;
	endfunction

	// sRGB gamma removal; below the knee it is a straight line
	function automatic longint unsigned gamma_expand(int c);
		longint unsigned s, q, lo, hi, mid;
		if (longint'(c) * 100000 <= 1031475)
			return (longint'(c) * 6553600 + 164730) / 329460;
		s = ((longint'(c) * 1000 + 14025) * 64'd16777216 + 134512) / 269025;
		q = (s * s) >> 24;
		lo = 0;
		hi = 64'd16777216;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (fifth_power_q24(mid) <= q)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (((q * lo) >> 24) + 128) >> 8;
	endfunction

	// Lab f(t), Q16 in, Q20 out: cube root above (6/29)^3, linear below
	function automatic longint unsigned lab_f(longint unsigned t);
		longint unsigned target, lo, hi, mid;
		if (t > 65536)
			t = 65536;
		if (t * 24389 > 14155776) begin
			target = t << 44;
			lo = 0;
			hi = 64'd1048576;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (mid * mid * mid <= target)
					lo = mid;
				else
					hi = mid - 1;
			end
			return lo;
		end
		return (390224 * t + 452984832 + 1566) / 3132;
	endfunction

	// divide by 2^20 with halves rounded up, for signed input
	function automatic longint round_shift20(longint n);
		return ((n + (longint'(1) << 40) + 524288) >>> 20) - (longint'(1) << 20);
	endfunction

	function automatic lab_color_t srgb_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		longint unsigned lin [3];
		longint unsigned f [3];
		longint unsigned acc;
		lab_color_t res;
		lin[0] = srgb_to_lin[r];
		lin[1] = srgb_to_lin[g];
		lin[2] = srgb_to_lin[b];
		for (int i = 0; i < 3; i++) begin
			acc = RGB2XYZ[i][0] * lin[0] + RGB2XYZ[i][1] * lin[1] + RGB2XYZ[i][2] * lin[2];
			f[i] = lab_f((acc + 32768) >> 16);
		end
		res.l = int'((7424 * f[1] + 524288) >> 20) - 1024;
		res.a = int'(round_shift20(32000 * (longint'(f[0]) - longint'(f[1]))));
		res.b = int'(round_shift20(12800 * (longint'(f[1]) - longint'(f[2]))));
		return res;
	endfunction

	// update palette or predict the match for one accepted request
	function automatic void predict_request(in_t req);
		lab_color_t c;
		longint unsigned dsq, best;
		longint dl, da, db;
		int n;
		out_t res;
		c = srgb_to_lab(req.red, req.green, req.blue);
		if (req.func == FUNC_LOAD) begin
			palette_model[req.entry_index] = c;
			return;
		end
		n = (count_model > DEPTH) ? DEPTH : count_model;
		res = '0;
		best = 0;
		for (int j = 0; j < n; j++) begin
			dl = c.l - palette_model[j].l;
			da = c.a - palette_model[j].a;
			db = c.b - palette_model[j].b;
			dsq = dl * dl + da * da + db * db;
			// strict less-than: the lowest slot wins a tie
			if (!res.found || dsq < best) begin
				best = dsq;
				res.match_index = 4'(j);
				res.found = 1'b1;
			end
		end
		expected_matches.push_back(res);
	endfunction

	// ---------------------------------------------------------------
	// Clock, reset, limit
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------
	// Request driver: valid holds until accepted; random gap bursts
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			tx_gap   <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				predict_request(in_data);
			if (tx_gap != 0) begin
				tx_gap   <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				tx_gap   <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_requests.size() != 0) begin
				in_data  <= pending_requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result side: stall bursts, plus the long hold-off when asked
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap    <= 0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
		end else if (rx_gap != 0) begin
			rx_gap    <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rx_gap    <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		long_hold = 1'b0;
		wait (hold_request === 1'b1);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (800) @(posedge clk);
		long_hold <= 1'b0;
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		out_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: index %0d found %0b",
						out_data.match_index, out_data.found);
			end else begin
				exp_res = expected_matches.pop_front();
				if (out_data.match_index !== exp_res.match_index ||
				    out_data.found !== exp_res.found) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected index %0d found %0b, got index %0d found %0b",
							exp_res.match_index, exp_res.found,
							out_data.match_index, out_data.found);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// only index 0 exists; writes with paddr[2] set are dropped
		if (addr[2] == REG_PALETTE_COUNT)
			count_model = value[4:0];
	endtask

	// sender pauses until every result is back, then lets loads finish
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_matches.size() != 0);
		repeat (160) @(posedge clk);
	endtask

	task automatic push_request(logic func, logic [3:0] slot, logic [7:0] r,
				    logic [7:0] g, logic [7:0] b);
		in_t req;
		req.func        = func;
		req.entry_index = slot;
		req.red         = r;
		req.green       = g;
		req.blue        = b;
		if (func == FUNC_LOAD) begin
			loaded_rgb[slot][0] = r;
			loaded_rgb[slot][1] = g;
			loaded_rgb[slot][2] = b;
		end
		pending_requests.push_back(req);
	endtask

	// mix of full range, extremes and low values across the linear segment of the gamma curve
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 12));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_phase(int unsigned items);
		int unsigned s;
		for (int unsigned k = 0; k < items; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2:
					push_request(FUNC_LOAD, 4'($urandom), pick_channel(),
						pick_channel(), pick_channel());
				3, 4: begin
					// exact palette color: zero distance, ties on duplicates
					s = $urandom_range(0, DEPTH - 1);
					push_request(FUNC_QUERY, 4'($urandom), loaded_rgb[s][0],
						loaded_rgb[s][1], loaded_rgb[s][2]);
				end
				default:
					push_request(FUNC_QUERY, 4'($urandom), pick_channel(),
						pick_channel(), pick_channel());
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		for (int c = 0; c < 256; c++)
			srgb_to_lin[c] = gamma_expand(c);
		for (int j = 0; j < DEPTH; j++)
			palette_model[j] = '{0, 0, 0};
		count_model  = '0;
		mismatches   = 0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty palette after reset: query reports not found
		push_request(FUNC_QUERY, 4'hF, 8'd255, 8'd255, 8'd255);
		push_request(FUNC_QUERY, 4'h0, 8'd0, 8'd0, 8'd0);
		// fill every slot: extremes, primaries, a duplicate for the tie case
		push_request(FUNC_LOAD, 4'd0, 8'd0, 8'd0, 8'd0);
		push_request(FUNC_LOAD, 4'd1, 8'd255, 8'd255, 8'd255);
		push_request(FUNC_LOAD, 4'd2, 8'd255, 8'd0, 8'd0);
		push_request(FUNC_LOAD, 4'd3, 8'd0, 8'd255, 8'd0);
		push_request(FUNC_LOAD, 4'd4, 8'd0, 8'd0, 8'd255);
		push_request(FUNC_LOAD, 4'd5, 8'd10, 8'd10, 8'd10);
		push_request(FUNC_LOAD, 4'd6, 8'd11, 8'd128, 8'd200);
		push_request(FUNC_LOAD, 4'd7, 8'd255, 8'd0, 8'd0);
		for (int j = 8; j < DEPTH; j++)
			push_request(FUNC_LOAD, 4'(j), 8'($urandom), 8'($urandom), 8'($urandom));
		wait_idle();

		// write to a missing register index must not change the count
		reg_write(3'd4, 32'd16);
		pending_requests.push_back('{FUNC_QUERY, 4'd0, 8'd9, 8'd9, 8'd9});
		wait_idle();

		reg_write(3'd0, 32'd16);
		push_request(FUNC_QUERY, 4'd0, 8'd0, 8'd0, 8'd0);
		push_request(FUNC_QUERY, 4'd15, 8'd255, 8'd255, 8'd255);
		push_request(FUNC_QUERY, 4'd5, 8'd255, 8'd0, 8'd0);  // tie of slots 2 and 7
		push_request(FUNC_QUERY, 4'd9, 8'd0, 8'd255, 8'd0);
		push_request(FUNC_QUERY, 4'd10, 8'd0, 8'd0, 8'd255);
		push_request(FUNC_QUERY, 4'd3, 8'd10, 8'd11, 8'd12);
		push_request(FUNC_QUERY, 4'd6, 8'd170, 8'd85, 8'd51);
		wait_idle();

		// count above depth saturates
		reg_write(3'd0, 32'd31);
		random_phase(250);
		hold_request = 1'b1;
		wait_idle();

		reg_write(3'd0, 32'd1);
		random_phase(200);
		wait_idle();

		reg_write(3'd0, 32'd0);
		random_phase(60);
		wait_idle();

		reg_write(3'd0, 32'($urandom_range(2, 15)));
		random_phase(300);
		wait_idle();

		reg_write(3'd0, 32'd17);
		random_phase(300);
		wait_idle();

		// last stretch without any idling on either side
		reg_write(3'd0, 32'd16);
		quiet = 1'b1;
		random_phase(450);
		wait_idle();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
design/npcl_pkg.sv
design/nearest_palette_color_lab.sv
verif/testbench.sv
